/* design/mmr_pkg.sv */
// Package for the mesh multicast router: sizes, port codes, status codes, config indices, FSM states and structs.
// Has no dependencies; every other design file imports it.
`timescale 1ns / 1ps
package mmr_pkg;
  localparam int unsigned NumPorts = 5;
  localparam int unsigned DefQueueDepth = 4;
  localparam int unsigned DefMaxDests = 8;
  localparam int unsigned DefCoordBits = 4;
  localparam int unsigned DefPayloadBits = 64;

  localparam logic [2:0] PortLocal = 3'd0;
  localparam logic [2:0] PortEast  = 3'd1;
  localparam logic [2:0] PortWest  = 3'd2;
  localparam logic [2:0] PortNorth = 3'd3;
  localparam logic [2:0] PortSouth = 3'd4;

  localparam logic [1:0] StAccept = 2'd0;
  localparam logic [1:0] StReject = 2'd1;
  localparam logic [1:0] StPopped = 2'd2;
  localparam logic [1:0] StEmpty  = 2'd3;

  localparam logic [1:0] CfgNodeX = 2'd0;
  localparam logic [1:0] CfgNodeY = 2'd1;
  localparam logic [1:0] CfgOrder = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_COMMIT, S_COPY, S_POP_RD, S_POP_EMIT, S_SINGLE
  } state_e;

  typedef struct packed {
    logic add;       // store the current destination
    logic commit;    // evaluate and enqueue the pending message
    logic copy;      // move one pending destination into the queue memory
    logic pop_rd;    // read the head slot of the pop port
    logic emit;      // drive a popped destination on the output
    logic single;    // drive a one-word status result
    logic out_taken; // the current output word was taken
  } cmd_t;

  typedef struct packed {
    logic       is_pop;
    logic       is_last;
    logic       pop_ok;
    logic       emit_last;
    logic       commit_ok;
    logic       copy_last;
  } sts_t;
endpackage

/* design/mesh_multicast_router_unit.sv */
// Top level of the mesh multicast router: joins controller and datapath.
// Depends on mmr_pkg, mmr_ctrl and mmr_datapath.
`timescale 1ns / 1ps
// Channel  | Dir | Handshake             | Payload
// s_axis   | in  | tvalid/tready         | tdata (commands and destinations)
// m_axis   | out | tvalid/tready, tlast  | tuser status, tdata popped word
// cfg      | in  | cfg_we_i              | cfg_idx_i, cfg_data_i
// Each destination word is added to the pending message; the last one is followed by a commit and,
// when the message is accepted, a copy of each destination into the queue memory.
// A pop reads each destination word through the registered queue memory, then emits it.
// A commit status follows its commit and, on accept, its copy; an empty pop status comes
// in the cycle after the word is taken. Reset clears all queues.
// Input is not taken while a result is pending on the output.
module mesh_multicast_router_unit #(
  parameter int unsigned QueueDepth  = mmr_pkg::DefQueueDepth,
  parameter int unsigned MaxDests    = mmr_pkg::DefMaxDests,
  parameter int unsigned CoordBits   = mmr_pkg::DefCoordBits,
  parameter int unsigned PayloadBits = mmr_pkg::DefPayloadBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [3:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op, dest_x, dest_y, group_slot, bit_width, output_index, spike_payload, pop_port
  input  logic [111:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_group, out_width, out_index, out_payload
  output logic [103:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import mmr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mmr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  mmr_datapath #(
    .QueueDepth(QueueDepth), .MaxDests(MaxDests),
    .CoordBits(CoordBits), .PayloadBits(PayloadBits)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_op_i(s_axis_tdata[0]), .in_x_i(s_axis_tdata[4:1]), .in_y_i(s_axis_tdata[8:5]),
    .in_group_i(s_axis_tdata[16:9]), .in_last_i(s_axis_tlast),
    .in_width_i(s_axis_tdata[23:17]), .in_index_i(s_axis_tdata[39:24]),
    .in_payload_i(s_axis_tdata[103:40]), .in_pop_port_i(s_axis_tdata[106:104]),
    .cmd_i(cmd), .sts_o(sts),
    .out_status_o(m_axis_tuser), .out_x_o(m_axis_tdata[3:0]), .out_y_o(m_axis_tdata[7:4]),
    .out_group_o(m_axis_tdata[15:8]), .out_width_o(m_axis_tdata[22:16]),
    .out_index_o(m_axis_tdata[38:23]), .out_payload_o(m_axis_tdata[102:39]),
    .out_last_o(m_axis_tlast)
  );
  assign m_axis_tdata[103] = 1'b0;
endmodule

/* design/mmr_ctrl.sv */
// Controller state machine of the mesh multicast router.
// Depends on mmr_pkg for the state type and command/status structs.
`timescale 1ns / 1ps
module mmr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  mmr_pkg::sts_t  sts_i,
  output mmr_pkg::cmd_t  cmd_o
);
  import mmr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.is_pop) begin
            cmd_o.pop_rd = 1'b1;
            state_d = sts_i.pop_ok ? S_POP_RD : S_SINGLE;
          end else begin
            cmd_o.add = 1'b1;
            if (sts_i.is_last) state_d = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = sts_i.commit_ok ? S_COPY : S_SINGLE;
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (sts_i.copy_last) state_d = S_SINGLE;
      end
      S_POP_RD: begin
        state_d = S_POP_EMIT;
      end
      S_POP_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.emit = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_taken = 1'b1;
          state_d = sts_i.emit_last ? S_IDLE : S_POP_RD;
        end
      end
      S_SINGLE: begin
        out_valid_o = 1'b1;
        cmd_o.single = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_taken = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output active together");
  a_commit_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit && !sts_i.commit_ok) |=> out_valid_o)
    else $error("commit not followed by result");
  a_copy_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.copy && sts_i.copy_last) |=> out_valid_o)
    else $error("copy not followed by result");
  a_rd_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_RD) |=> out_valid_o) else $error("read not followed by emit");
endmodule

/* design/mmr_datapath.sv */
// Datapath of the mesh multicast router: steering, pending message, port queues.
// Depends on mmr_pkg for codes and command/status structs.
`timescale 1ns / 1ps
module mmr_datapath #(
  parameter int unsigned QueueDepth  = mmr_pkg::DefQueueDepth,
  parameter int unsigned MaxDests    = mmr_pkg::DefMaxDests,
  parameter int unsigned CoordBits   = mmr_pkg::DefCoordBits,
  parameter int unsigned PayloadBits = mmr_pkg::DefPayloadBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [3:0]    cfg_data_i,
  input  logic          in_op_i,
  input  logic [3:0]    in_x_i,
  input  logic [3:0]    in_y_i,
  input  logic [7:0]    in_group_i,
  input  logic          in_last_i,
  input  logic [6:0]    in_width_i,
  input  logic [15:0]   in_index_i,
  input  logic [63:0]   in_payload_i,
  input  logic [2:0]    in_pop_port_i,
  input  mmr_pkg::cmd_t cmd_i,
  output mmr_pkg::sts_t sts_o,
  output logic [1:0]    out_status_o,
  output logic [3:0]    out_x_o,
  output logic [3:0]    out_y_o,
  output logic [7:0]    out_group_o,
  output logic [6:0]    out_width_o,
  output logic [15:0]   out_index_o,
  output logic [63:0]   out_payload_o,
  output logic          out_last_o
);
  import mmr_pkg::*;

  localparam int unsigned QW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FW = $clog2(QueueDepth + 1);
  localparam int unsigned DW = (MaxDests > 1) ? $clog2(MaxDests) : 1;
  localparam int unsigned CW = $clog2(MaxDests + 1);
  localparam int unsigned MemDepth = NumPorts * QueueDepth;
  localparam int unsigned MW = $clog2(MemDepth);
  localparam int unsigned DestBits = 2 * CoordBits + 8;

  logic [CoordBits-1:0] node_x_q, node_y_q;
  logic                 order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_x_q <= '0;
      node_y_q <= '0;
      order_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNodeX: node_x_q <= cfg_data_i[CoordBits-1:0];
        CfgNodeY: node_y_q <= cfg_data_i[CoordBits-1:0];
        CfgOrder: order_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [CoordBits-1:0] cx, cy;
  logic [2:0] port;
  assign cx = in_x_i[CoordBits-1:0];
  assign cy = in_y_i[CoordBits-1:0];

  always_comb begin
    logic [2:0] xd, yd;
    xd = (cx > node_x_q) ? PortEast : PortWest;
    yd = (cy > node_y_q) ? PortSouth : PortNorth;
    if (cx == node_x_q && cy == node_y_q) port = PortLocal;
    else if (!order_q) port = (cx != node_x_q) ? xd : yd;
    else port = (cy != node_y_q) ? yd : xd;
  end

  // Pending message state; destinations are kept in arrival order with their port.
  logic [CW-1:0] pcnt_q [NumPorts];
  logic [CW-1:0] ptot_q;
  logic          povf_q;
  logic [DestBits+2:0] plist_q [MaxDests];
  logic [6:0]  cw_q;
  logic [15:0] ci_q;
  logic [PayloadBits-1:0] cp_q;

  // Copy of an accepted message into the queue memory, one destination a cycle.
  logic [CW-1:0] ctot_q, cpos_q;
  logic [CW-1:0] wcnt_q [NumPorts];
  logic [MW-1:0] slot_q [NumPorts];
  logic [2:0]    cport;
  logic [DestBits-1:0] cdest;
  assign {cport, cdest} = plist_q[cpos_q[DW-1:0]];

  // Port queues: per-port control in flops, message data in memories.
  logic [FW-1:0] fill_q [NumPorts];
  logic [QW-1:0] head_q [NumPorts];
  logic [CW+7+16-1:0] hdr_mem [MemDepth];
  logic [PayloadBits-1:0] pay_mem [MemDepth];
  logic [DestBits-1:0] dst_mem [MemDepth][MaxDests];

  logic ok;
  always_comb begin
    ok = !povf_q && (ptot_q != '0);
    if (cw_q != '0 && ({25'd0, cw_q} > 32'(PayloadBits) || cw_q[2:0] != 3'd0)) ok = 1'b0;
    for (int p = 0; p < NumPorts; p++) begin
      if (pcnt_q[p] != '0 && fill_q[p] >= FW'(QueueDepth)) ok = 1'b0;
    end
  end

  function automatic logic [QW-1:0] wrap_add(logic [QW-1:0] h, logic [FW-1:0] f);
    logic [QW+FW:0] s;
    s = (QW+FW+1)'(h) + (QW+FW+1)'(f);
    if (s >= (QW+FW+1)'(QueueDepth)) s = s - (QW+FW+1)'(QueueDepth);
    return s[QW-1:0];
  endfunction

  function automatic logic [MW-1:0] maddr(int p, logic [QW-1:0] s);
    return MW'(p * QueueDepth) + MW'(s);
  endfunction

  // Pop path registers.
  logic [2:0]    pp_q;
  logic [MW-1:0] raddr_q;
  logic [DW-1:0] ri_q;
  logic [CW-1:0] rn_q;
  logic [CW+7+16-1:0] rhdr_q;
  logic [PayloadBits-1:0] rpay_q;
  logic [DestBits-1:0] rdst_q;
  logic [1:0] sst_q;

  logic pop_ok;
  assign pop_ok = (in_pop_port_i < 3'(NumPorts)) && (fill_q[in_pop_port_i] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptot_q <= '0;
      povf_q <= 1'b0;
      ri_q   <= '0;
      for (int p = 0; p < NumPorts; p++) begin
        pcnt_q[p] <= '0;
        fill_q[p] <= '0;
        head_q[p] <= '0;
      end
    end else begin
      if (cmd_i.add) begin
        if (ptot_q >= CW'(MaxDests)) povf_q <= 1'b1;
        else begin
          pcnt_q[port] <= pcnt_q[port] + 1'b1;
          ptot_q <= ptot_q + 1'b1;
        end
      end
      if (cmd_i.commit) begin
        for (int p = 0; p < NumPorts; p++) begin
          if (ok && pcnt_q[p] != '0) fill_q[p] <= fill_q[p] + 1'b1;
          pcnt_q[p] <= '0;
        end
        ptot_q <= '0;
        povf_q <= 1'b0;
      end
      if (cmd_i.pop_rd && pop_ok) ri_q <= '0;
      if (cmd_i.emit && cmd_i.out_taken) begin
        ri_q <= ri_q + 1'b1;
        if (sts_o.emit_last) begin
          fill_q[pp_q] <= fill_q[pp_q] - 1'b1;
          head_q[pp_q] <= (head_q[pp_q] == QW'(QueueDepth - 1)) ? '0 : head_q[pp_q] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      if (ptot_q < CW'(MaxDests)) plist_q[ptot_q[DW-1:0]] <= {port, cx, cy, in_group_i};
      cw_q <= in_width_i;
      ci_q <= in_index_i;
      cp_q <= in_payload_i[PayloadBits-1:0];
    end
    if (cmd_i.pop_rd) begin
      pp_q <= in_pop_port_i;
      if (pop_ok) raddr_q <= maddr(int'(in_pop_port_i), head_q[in_pop_port_i]);
      sst_q <= StEmpty;
    end
    if (cmd_i.commit) begin
      sst_q  <= ok ? StAccept : StReject;
      ctot_q <= ptot_q;
      cpos_q <= '0;
      for (int p = 0; p < NumPorts; p++) begin
        wcnt_q[p] <= '0;
        slot_q[p] <= maddr(p, wrap_add(head_q[p], fill_q[p]));
      end
    end
    if (cmd_i.copy) begin
      wcnt_q[cport] <= wcnt_q[cport] + 1'b1;
      cpos_q <= cpos_q + 1'b1;
    end
  end

  // Memory writes: header and payload on commit, destinations during the copy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ok) begin
      for (int p = 0; p < NumPorts; p++) begin
        if (pcnt_q[p] != '0) begin
          hdr_mem[maddr(p, wrap_add(head_q[p], fill_q[p]))] <= {ci_q, cw_q, pcnt_q[p]};
          pay_mem[maddr(p, wrap_add(head_q[p], fill_q[p]))] <= cp_q;
        end
      end
    end
    if (cmd_i.copy) dst_mem[slot_q[cport]][wcnt_q[cport][DW-1:0]] <= cdest;
  end

  // Registered memory reads.
  always_ff @(posedge clk_i) begin
    rhdr_q <= hdr_mem[raddr_q];
    rpay_q <= pay_mem[raddr_q];
    rdst_q <= dst_mem[raddr_q][ri_q];
  end

  always_comb begin
    rn_q = rhdr_q[CW-1:0];
    if (rn_q > CW'(MaxDests)) rn_q = CW'(MaxDests);
  end

  assign sts_o.is_pop    = in_op_i;
  assign sts_o.is_last   = in_last_i;
  assign sts_o.pop_ok    = pop_ok;
  assign sts_o.emit_last = (CW'(ri_q) + 1'b1 >= rn_q);
  assign sts_o.commit_ok = ok;
  assign sts_o.copy_last = (cpos_q + 1'b1 == ctot_q);

  always_comb begin
    out_status_o  = sst_q;
    out_x_o       = '0;
    out_y_o       = '0;
    out_group_o   = '0;
    out_width_o   = '0;
    out_index_o   = '0;
    out_payload_o = '0;
    out_last_o    = 1'b1;
    if (cmd_i.emit) begin
      out_status_o  = StPopped;
      out_x_o       = 4'(rdst_q[DestBits-1 -: CoordBits]);
      out_y_o       = 4'(rdst_q[8 +: CoordBits]);
      out_group_o   = rdst_q[7:0];
      out_width_o   = rhdr_q[CW +: 7];
      out_index_o   = rhdr_q[CW+7 +: 16];
      out_payload_o = 64'(rpay_q);
      out_last_o    = sts_o.emit_last;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[0] <= FW'(QueueDepth)) else $error("queue overfilled");
  a_tot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptot_q <= CW'(MaxDests)) else $error("pending count too large");
  a_commit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (ptot_q == '0 && !povf_q)) else $error("pending not cleared");
endmodule
